@@ rtl/core/crfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera / radar fusion qualifier package
// Shared codes, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package crfq_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Fixed register widths.
  localparam int AGE_W = 16;
  localparam int THR_W = 8;
  localparam int TOL_W = 12;
  localparam int DIST_W = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CAMERA_MAX_AGE = 3'd0,
    REG_RADAR_MAX_AGE  = 3'd1,
    REG_TIME_TOLERANCE = 3'd2,
    REG_HOLD           = 3'd3,
    REG_HIT_THRESHOLD  = 3'd4,
    REG_MISS_THRESHOLD = 3'd5,
    REG_CENTER_TOL     = 3'd6
  } reg_index_t;

  // Register reset values.
  localparam logic [AGE_W-1:0] RST_CAMERA_MAX_AGE = 16'd500;
  localparam logic [AGE_W-1:0] RST_RADAR_MAX_AGE  = 16'd500;
  localparam logic [AGE_W-1:0] RST_TIME_TOLERANCE = 16'd200;
  localparam logic [AGE_W-1:0] RST_HOLD           = 16'd300;
  localparam logic [THR_W-1:0] RST_HIT_THRESHOLD  = 8'd3;
  localparam logic [THR_W-1:0] RST_MISS_THRESHOLD = 8'd3;
  localparam logic [TOL_W-1:0] RST_CENTER_TOL     = 12'd20;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_CAMERA      = 2'd0,
    OP_RADAR       = 2'd1,
    OP_SECOND_POSE = 2'd2,
    OP_TASK_RESET  = 2'd3
  } op_t;

  // Task stage codes.
  localparam logic [1:0] STAGE_FIRST  = 2'd0;
  localparam logic [1:0] STAGE_MOVING = 2'd1;
  localparam logic [1:0] STAGE_SECOND = 2'd2;

  // Move hint codes.
  localparam logic [1:0] HINT_NONE = 2'd0;
  localparam logic [1:0] HINT_NEAR = 2'd1;
  localparam logic [1:0] HINT_FAR  = 2'd2;

  // Configuration bundle handed from the register file to the datapath.
  typedef struct packed {
    logic [AGE_W-1:0] camera_max_age;
    logic [AGE_W-1:0] radar_max_age;
    logic [AGE_W-1:0] time_tolerance;
    logic [AGE_W-1:0] hold;
    logic [THR_W-1:0] hit_threshold;
    logic [THR_W-1:0] miss_threshold;
    logic [TOL_W-1:0] center_tol;
  } cfg_t;

endpackage

@@ rtl/core/crfq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera / radar fusion qualifier channels
// Valid/ready channels for report words and result words.
// ----------------------------------------------------------------------------
interface crfq_report_if #(
  parameter int TIME_BITS = 48,
  parameter int ROW_BITS  = 12
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [TIME_BITS-1:0] now_ms;
  logic                 report_found;
  logic [TIME_BITS-1:0] report_time_ms;
  logic [ROW_BITS-1:0]  target_row;
  logic [15:0]          target_distance_mm;
  logic [ROW_BITS-1:0]  image_height;

  modport source (
    output valid, op, now_ms, report_found, report_time_ms, target_row,
           target_distance_mm, image_height,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, report_found, report_time_ms, target_row,
           target_distance_mm, image_height,
    output ready
  );
endinterface

interface crfq_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  stage;
  logic        fused_now;
  logic        stable;
  logic        centered;
  logic [1:0]  move_hint;
  logic        first_done;
  logic [15:0] first_distance_mm;
  logic        second_ready;

  modport source (
    output valid, stage, fused_now, stable, centered, move_hint, first_done,
           first_distance_mm, second_ready,
    input  ready
  );
  modport sink (
    input  valid, stage, fused_now, stable, centered, move_hint, first_done,
           first_distance_mm, second_ready,
    output ready
  );
endinterface

@@ rtl/core/camera_radar_fusion_qualifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera / radar fusion qualifier
// Fuses the latest camera and radar target reports, debounces the result and
// sequences a two-pose detect task.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake       Word
//  --------  ---  --------------  ---------------------------------------------
//  report    in   valid / ready   op, now_ms, report fields, image_height
//  result    out  valid / ready   stage, fusion flags, hint, pulses, distance
//  cfg_*     in   cfg_write only  register index and data, no back-pressure
//
//  Every report word yields exactly one result word, which passes from the
//  input register through the evaluation into the result register; a stall
//  of the result side holds it in the input register. One word per cycle is
//  sustained while the result side does not stall: the evaluation is a single
//  stage of compares and counters between the registers. Reset is synchronous
//  and clears all fusion and task state and loads the register defaults. A
//  stalled result register holds its word; the input register keeps taking
//  words until both registers are full.
//
module camera_radar_fusion_qualifier import crfq_pkg::*; #(
  parameter int TIME_BITS  = 48,
  parameter int ROW_BITS   = 12,
  parameter int COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  crfq_report_if.sink            report,
  crfq_result_if.source          result
);

  // Width for comparing counters against the 8-bit thresholds.
  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  // Width for comparing a row offset against the 12-bit tolerance.
  localparam int ROFF_W = (ROW_BITS > TOL_W) ? ROW_BITS : TOL_W;
  // Width holding three times (row + 1).
  localparam int ROW3_W = ROW_BITS + 3;

  // Register bundle.
  cfg_t cfg;

  crfq_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                 in_valid;
  op_t                  in_op;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_found;
  logic [TIME_BITS-1:0] in_rtime;
  logic [ROW_BITS-1:0]  in_row;
  logic [DIST_W-1:0]    in_dist;
  logic [ROW_BITS-1:0]  in_height;

  logic advance;
  logic out_valid;

  // The evaluated word moves into the result register when that register is
  // empty or is being emptied in the same cycle.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign report.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (report.valid && report.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report.valid && report.ready) begin
      in_op     <= op_t'(report.op);
      in_now    <= report.now_ms;
      in_found  <= report.report_found;
      in_rtime  <= report.report_time_ms;
      in_row    <= report.target_row;
      in_dist   <= report.target_distance_mm;
      in_height <= report.image_height;
    end
  end

  // --------------------------------------------------------------------------
  // Fusion and task state
  // --------------------------------------------------------------------------
  logic [1:0]            stage_reg;
  logic                  cam_found;
  logic [TIME_BITS-1:0]  cam_time;
  logic [ROW_BITS-1:0]   cam_row;
  logic                  radar_found;
  logic [TIME_BITS-1:0]  radar_time;
  logic [DIST_W-1:0]     radar_dist;
  logic [ROW_BITS-1:0]   frame_height;
  logic [TIME_BITS-1:0]  last_match_time;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] miss_count;
  logic                  stable_flag;
  logic                  second_cmd_sent;
  logic                  stage2_sent;
  logic [DIST_W-1:0]     latched_dist;

  logic [1:0]            stage_reg_next;
  logic                  cam_found_next;
  logic [TIME_BITS-1:0]  cam_time_next;
  logic [ROW_BITS-1:0]   cam_row_next;
  logic                  radar_found_next;
  logic [TIME_BITS-1:0]  radar_time_next;
  logic [DIST_W-1:0]     radar_dist_next;
  logic [ROW_BITS-1:0]   frame_height_next;
  logic [TIME_BITS-1:0]  last_match_time_next;
  logic [COUNT_BITS-1:0] hit_count_next;
  logic [COUNT_BITS-1:0] miss_count_next;
  logic                  stable_flag_next;
  logic                  second_cmd_sent_next;
  logic                  stage2_sent_next;
  logic [DIST_W-1:0]     latched_dist_next;

  // True when t is no older than limit at time now; a time in the future
  // counts as current.
  function automatic logic within_age(
    input logic [TIME_BITS-1:0] now,
    input logic [TIME_BITS-1:0] t,
    input logic [AGE_W-1:0]     limit
  );
    logic [TIME_BITS-1:0] age;
    age = now - t;
    return (t >= now) || (age <= TIME_BITS'(limit));
  endfunction

  // --------------------------------------------------------------------------
  // Report store update
  // --------------------------------------------------------------------------
  // A camera target in the top third of the frame is suppressed in stage one.
  // row < height / 3 is the same as 3 * (row + 1) <= height.
  logic [ROW3_W-1:0] row_plus1;
  logic [ROW3_W-1:0] row_times3;
  logic              top_third;

  assign row_plus1  = ROW3_W'(in_row) + ROW3_W'(1);
  assign row_times3 = (row_plus1 << 1) + row_plus1;
  assign top_third  = row_times3 <= ROW3_W'(in_height);

  always_comb begin
    cam_found_next    = cam_found;
    cam_time_next     = cam_time;
    cam_row_next      = cam_row;
    radar_found_next  = radar_found;
    radar_time_next   = radar_time;
    radar_dist_next   = radar_dist;
    frame_height_next = frame_height;
    case (in_op)
      OP_CAMERA: begin
        frame_height_next = in_height;
        cam_found_next    = in_found && !((stage_reg == STAGE_FIRST) && top_third);
        cam_time_next     = in_rtime;
        cam_row_next      = in_row;
      end
      OP_RADAR: begin
        frame_height_next = in_height;
        radar_found_next  = in_found;
        radar_time_next   = in_rtime;
        radar_dist_next   = in_dist;
      end
      OP_SECOND_POSE: begin
        // Stored reports are dropped; the frame height is kept.
        cam_found_next   = 1'b0;
        cam_time_next    = '0;
        cam_row_next     = '0;
        radar_found_next = 1'b0;
        radar_time_next  = '0;
        radar_dist_next  = '0;
      end
      default: begin
        cam_found_next    = 1'b0;
        cam_time_next     = '0;
        cam_row_next      = '0;
        radar_found_next  = 1'b0;
        radar_time_next   = '0;
        radar_dist_next   = '0;
        frame_height_next = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Centring check against half the frame height, on the updated store
  // --------------------------------------------------------------------------
  logic [ROW_BITS-1:0] half_height;
  logic [ROW_BITS-1:0] row_dev;
  logic                row_below;
  logic                row_ok;

  assign half_height = frame_height_next >> 1;
  assign row_below   = cam_row_next > half_height;
  assign row_dev     = row_below ? (cam_row_next - half_height)
                                 : (half_height - cam_row_next);
  assign row_ok      = ROFF_W'(row_dev) <= ROFF_W'(cfg.center_tol);

  // --------------------------------------------------------------------------
  // Freshness, time agreement and hold window
  // --------------------------------------------------------------------------
  logic                 cam_fresh;
  logic                 radar_fresh;
  logic [TIME_BITS-1:0] time_gap;
  logic                 gap_ok;
  logic                 held;

  assign cam_fresh   = cam_found_next && (cam_time_next != '0) &&
                       within_age(in_now, cam_time_next, cfg.camera_max_age);
  assign radar_fresh = radar_found_next && (radar_time_next != '0) &&
                       within_age(in_now, radar_time_next, cfg.radar_max_age);
  assign time_gap    = (cam_time_next >= radar_time_next)
                       ? (cam_time_next - radar_time_next)
                       : (radar_time_next - cam_time_next);
  assign gap_ok      = time_gap <= TIME_BITS'(cfg.time_tolerance);
  assign held        = within_age(in_now, last_match_time, cfg.hold);

  // --------------------------------------------------------------------------
  // Debounce and task sequencing
  // --------------------------------------------------------------------------
  logic       fused;
  logic       first_done_now;
  logic       second_ready_now;
  logic       centered_now;
  logic [1:0] hint_now;

  always_comb begin
    stage_reg_next       = stage_reg;
    last_match_time_next = last_match_time;
    hit_count_next       = hit_count;
    miss_count_next      = miss_count;
    stable_flag_next     = stable_flag;
    second_cmd_sent_next = second_cmd_sent;
    stage2_sent_next     = stage2_sent;
    latched_dist_next    = latched_dist;
    fused                = 1'b0;
    first_done_now       = 1'b0;
    second_ready_now     = 1'b0;

    case (in_op)
      OP_SECOND_POSE: begin
        stage_reg_next       = STAGE_SECOND;
        second_cmd_sent_next = 1'b0;
        stable_flag_next     = 1'b0;
        hit_count_next       = '0;
        miss_count_next      = '0;
        last_match_time_next = '0;
        stage2_sent_next     = 1'b0;
      end
      OP_TASK_RESET: begin
        stage_reg_next       = STAGE_FIRST;
        second_cmd_sent_next = 1'b0;
        latched_dist_next    = '0;
        stable_flag_next     = 1'b0;
        hit_count_next       = '0;
        miss_count_next      = '0;
        last_match_time_next = '0;
        stage2_sent_next     = 1'b0;
      end
      default: begin
        // A direct match refreshes the hold window; otherwise a recent match
        // keeps fusion alive.
        if (cam_fresh && radar_fresh) begin
          if (gap_ok) begin
            fused                = 1'b1;
            last_match_time_next = in_now;
          end else if (held) begin
            fused = 1'b1;
          end
        end

        // Saturating hit and miss counters.
        if (fused) begin
          if (!(&hit_count)) begin
            hit_count_next = hit_count + COUNT_BITS'(1);
          end
          miss_count_next = '0;
        end else begin
          if (!(&miss_count)) begin
            miss_count_next = miss_count + COUNT_BITS'(1);
          end
          hit_count_next = '0;
        end

        case (stage_reg)
          STAGE_FIRST: begin
            if (!stable_flag && (CMP_W'(hit_count_next) >= CMP_W'(cfg.hit_threshold))) begin
              stable_flag_next = 1'b1;
            end
            if (stable_flag_next && fused && !second_cmd_sent && row_ok) begin
              second_cmd_sent_next = 1'b1;
              latched_dist_next    = radar_dist_next;
              stage_reg_next       = STAGE_MOVING;
              first_done_now       = 1'b1;
            end
          end
          STAGE_SECOND: begin
            if (!stable_flag && (CMP_W'(hit_count_next) >= CMP_W'(cfg.hit_threshold))) begin
              stable_flag_next = 1'b1;
            end
            if (stable_flag_next && fused && row_ok && !stage2_sent) begin
              stage2_sent_next = 1'b1;
              second_ready_now = 1'b1;
            end
          end
          default: begin
            // While moving, stable is never raised.
          end
        endcase

        // Enough consecutive misses drop the stable flag; in stage one this
        // also re-arms the move command.
        if (stable_flag_next &&
            (CMP_W'(miss_count_next) >= CMP_W'(cfg.miss_threshold))) begin
          stable_flag_next = 1'b0;
          if (stage_reg_next == STAGE_FIRST) begin
            second_cmd_sent_next = 1'b0;
          end
        end
      end
    endcase

    centered_now = stable_flag_next && row_ok;
    if ((stage_reg_next == STAGE_SECOND) && stable_flag_next && !centered_now) begin
      hint_now = row_below ? HINT_NEAR : HINT_FAR;
    end else begin
      hint_now = HINT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_reg       <= STAGE_FIRST;
      cam_found       <= 1'b0;
      cam_time        <= '0;
      cam_row         <= '0;
      radar_found     <= 1'b0;
      radar_time      <= '0;
      radar_dist      <= '0;
      frame_height    <= '0;
      last_match_time <= '0;
      hit_count       <= '0;
      miss_count      <= '0;
      stable_flag     <= 1'b0;
      second_cmd_sent <= 1'b0;
      stage2_sent     <= 1'b0;
      latched_dist    <= '0;
    end else if (advance) begin
      stage_reg       <= stage_reg_next;
      cam_found       <= cam_found_next;
      cam_time        <= cam_time_next;
      cam_row         <= cam_row_next;
      radar_found     <= radar_found_next;
      radar_time      <= radar_time_next;
      radar_dist      <= radar_dist_next;
      frame_height    <= frame_height_next;
      last_match_time <= last_match_time_next;
      hit_count       <= hit_count_next;
      miss_count      <= miss_count_next;
      stable_flag     <= stable_flag_next;
      second_cmd_sent <= second_cmd_sent_next;
      stage2_sent     <= stage2_sent_next;
      latched_dist    <= latched_dist_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.stage             <= stage_reg_next;
      result.fused_now         <= fused;
      result.stable            <= stable_flag_next;
      result.centered          <= centered_now;
      result.move_hint         <= hint_now;
      result.first_done        <= first_done_now;
      result.first_distance_mm <= latched_dist_next;
      result.second_ready      <= second_ready_now;
    end
  end

  assign result.valid = out_valid;

endmodule

@@ rtl/core/crfq_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera / radar fusion qualifier configuration registers
// Decodes writes from the configuration port into the register bundle.
// ----------------------------------------------------------------------------
module crfq_cfg_regs import crfq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.camera_max_age <= RST_CAMERA_MAX_AGE;
      cfg.radar_max_age  <= RST_RADAR_MAX_AGE;
      cfg.time_tolerance <= RST_TIME_TOLERANCE;
      cfg.hold           <= RST_HOLD;
      cfg.hit_threshold  <= RST_HIT_THRESHOLD;
      cfg.miss_threshold <= RST_MISS_THRESHOLD;
      cfg.center_tol     <= RST_CENTER_TOL;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CAMERA_MAX_AGE: cfg.camera_max_age <= cfg_data[AGE_W-1:0];
        REG_RADAR_MAX_AGE:  cfg.radar_max_age  <= cfg_data[AGE_W-1:0];
        REG_TIME_TOLERANCE: cfg.time_tolerance <= cfg_data[AGE_W-1:0];
        REG_HOLD:           cfg.hold           <= cfg_data[AGE_W-1:0];
        REG_HIT_THRESHOLD:  cfg.hit_threshold  <= cfg_data[THR_W-1:0];
        REG_MISS_THRESHOLD: cfg.miss_threshold <= cfg_data[THR_W-1:0];
        REG_CENTER_TOL:     cfg.center_tol     <= cfg_data[TOL_W-1:0];
        default: begin
          // Unused index: the write is dropped.
        end
      endcase
    end
  end

endmodule
